// ===== hdl/cdq_pkg.sv =====
// Shared types, codes and constants for the circular deque.
package cdq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned OCC_W         = 5;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_EXEC,
    CTL_RESP
  } ctl_state_e;

  typedef struct packed {
    op_e                       mode;
    logic signed [DATA_W-1:0]  data_in;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]  data_out;
    status_e                   status;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_empty;
    logic                      is_full;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the request
    logic exec;     // update pointers, access the store
    logic respond;  // present the result
  } cdq_cmd_t;

endpackage

// ===== hdl/cdq_ctrl.sv =====
// Sequencer: accept, execute, respond.
module cdq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  output cdq_pkg::cdq_cmd_t cmd_o
);
  import cdq_pkg::*;

  ctl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    unique case (state_q)
      CTL_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = CTL_EXEC;
        end
      end
      CTL_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = CTL_RESP;
      end
      CTL_RESP: begin
        cmd_o.respond = 1'b1;
        state_d       = CTL_IDLE;
      end
      default: state_d = CTL_IDLE;
    endcase
  end

endmodule

// ===== hdl/cdq_dpath.sv =====
// Pointers, count, storage array and result formation.
module cdq_dpath #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cdq_pkg::cdq_cmd_t cmd_i,
  input  cdq_pkg::req_t     req_i,
  output cdq_pkg::rsp_t     rsp_o,
  output logic              valid_o
);
  import cdq_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  logic [DATA_W-1:0] mem_q [DEPTH];

  req_t          req_q;
  logic [AW-1:0] head_q, head_d, tail_q, tail_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0] rd_q;
  status_e       status_q, status_d;
  logic          pop_ok_q, pop_ok_d;

  logic          full, empty;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;

  assign full  = (cnt_q == FULL_CNT);
  assign empty = (cnt_q == '0);

  assign head_inc = (head_q == LAST_IDX) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - AW'(1);
  assign tail_inc = (tail_q == LAST_IDX) ? '0 : tail_q + AW'(1);
  assign tail_dec = (tail_q == '0) ? LAST_IDX : tail_q - AW'(1);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    cnt_d    = cnt_q;
    status_d = ST_OK;
    pop_ok_d = 1'b0;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    wr_addr  = tail_q;
    rd_addr  = head_q;
    unique case (req_q.mode)
      OP_PUSH_BACK: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          wr_en   = cmd_i.exec;
          wr_addr = tail_q;
          tail_d  = tail_inc;
          cnt_d   = cnt_q + CW'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          status_d = ST_OVERFLOW;
        end else begin
          wr_en   = cmd_i.exec;
          wr_addr = head_dec;
          head_d  = head_dec;
          cnt_d   = cnt_q + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          rd_en    = cmd_i.exec;
          rd_addr  = head_q;
          head_d   = head_inc;
          cnt_d    = cnt_q - CW'(1);
          pop_ok_d = 1'b1;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_d = ST_UNDERFLOW;
        end else begin
          rd_en    = cmd_i.exec;
          rd_addr  = tail_dec;
          tail_d   = tail_dec;
          cnt_d    = cnt_q - CW'(1);
          pop_ok_d = 1'b1;
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else if (cmd_i.exec) begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      pop_ok_q <= pop_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= req_q.data_in;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  // count is already updated when the result goes out
  always_comb begin
    rsp_o.data_out  = pop_ok_q ? $signed(rd_q) : '0;
    rsp_o.status    = status_q;
    rsp_o.occupancy = OCC_W'(cnt_q);
    rsp_o.is_empty  = empty;
    rsp_o.is_full   = full;
  end

  assign valid_o = cmd_i.respond;

endmodule

// ===== hdl/circular_deque.sv =====
// Top level of the circular deque: controller plus datapath.
//
//   channel | ports                  | transaction when
//   --------+------------------------+------------------------------
//   request | start, busy, req_i     | start high and busy low
//   result  | valid_o, rsp_o         | every cycle valid_o is high
//
// Each operation passes through accept, execute (pointer update and at most one
// store write or registered read) and respond. busy is high from the cycle
// after accept through the result cycle, so a new operation may start the
// cycle after valid_o. Reset clears pointers and count; stored words are
// undefined until written and need no clearing. The receiver cannot stall.
module circular_deque #(
  parameter int unsigned DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  cdq_pkg::req_t  req_i,
  output logic           valid_o,
  output cdq_pkg::rsp_t  rsp_o
);
  import cdq_pkg::*;

  cdq_cmd_t cmd;

  cdq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .req_i   (req_i),
    .rsp_o   (rsp_o),
    .valid_o (valid_o)
  );

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 valid_o)
    else $error("no result two cycles after accept");

  a_result_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy)
    else $error("result outside an operation");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == ST_OVERFLOW) |-> rsp_o.is_full)
    else $error("overflow reported while not full");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && rsp_o.status == ST_UNDERFLOW) |-> (rsp_o.is_empty && rsp_o.data_out == '0))
    else $error("underflow reported while not empty or with data");

endmodule

// ===== dv/circular_deque_tb.sv =====
// Self-checking testbench for circular_deque: directed table, then random ops vs. a deque predictor.
module circular_deque_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int unsigned DEPTH      = DEPTH_DEFAULT;
  localparam int          WDOG_LIMIT = 200;
  localparam int          N_RANDOM   = 1300;
  localparam int          DRAIN_CYC  = 10;

  typedef struct {
    op_e         op;
    logic [31:0] data;
    bit          typed;
    rsp_t        exp;
  } stim_row_t;

  logic  clk_i;
  logic  rst_ni;
  logic  start;
  logic  busy;
  req_t  req_i;
  logic  valid_o;
  rsp_t  rsp_o;

  // expectation typed into the directed table travels with the transaction
  bit    typed_chk;
  rsp_t  typed_rsp;

  // predictor state
  logic [DATA_W-1:0] dq_mem [DEPTH];
  int unsigned       dq_head;
  int unsigned       dq_tail;
  int unsigned       dq_count;

  rsp_t        pending_rsp_q [$];
  stim_row_t   stim_tab [$];
  int          err_cnt;
  int          quiet_cycles;

  circular_deque #(.DEPTH(DEPTH)) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .req_i   (req_i),
    .valid_o (valid_o),
    .rsp_o   (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Applies one operation to the predicted deque and returns the result it yields.
  function automatic rsp_t deque_apply(req_t r);
    rsp_t o;
    o        = '0;
    o.status = ST_OK;
    case (r.mode)
      OP_PUSH_BACK: begin
        if (dq_count == DEPTH) begin
          o.status = ST_OVERFLOW;
        end else begin
          dq_mem[dq_tail] = r.data_in;
          dq_tail         = (dq_tail + 1) % DEPTH;
          dq_count++;
        end
      end
      OP_PUSH_FRONT: begin
        if (dq_count == DEPTH) begin
          o.status = ST_OVERFLOW;
        end else begin
          dq_head         = (dq_head + DEPTH - 1) % DEPTH;
          dq_mem[dq_head] = r.data_in;
          dq_count++;
        end
      end
      OP_POP_FRONT: begin
        if (dq_count == 0) begin
          o.status = ST_UNDERFLOW;
        end else begin
          o.data_out = dq_mem[dq_head];
          dq_head    = (dq_head + 1) % DEPTH;
          dq_count--;
        end
      end
      OP_POP_BACK: begin
        if (dq_count == 0) begin
          o.status = ST_UNDERFLOW;
        end else begin
          dq_tail    = (dq_tail + DEPTH - 1) % DEPTH;
          o.data_out = dq_mem[dq_tail];
          dq_count--;
        end
      end
      default: ;
    endcase
    o.occupancy = OCC_W'(dq_count);
    o.is_empty  = (dq_count == 0);
    o.is_full   = (dq_count == DEPTH);
    return o;
  endfunction

  task automatic compare_rsp(rsp_t got, rsp_t want);
    if (got.data_out !== want.data_out) begin
      $error("data_out: expected %h, got %h", want.data_out, got.data_out);
      err_cnt++;
    end
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      err_cnt++;
    end
    if (got.occupancy !== want.occupancy) begin
      $error("occupancy: expected %0d, got %0d", want.occupancy, got.occupancy);
      err_cnt++;
    end
    if (got.is_empty !== want.is_empty) begin
      $error("is_empty: expected %b, got %b", want.is_empty, got.is_empty);
      err_cnt++;
    end
    if (got.is_full !== want.is_full) begin
      $error("is_full: expected %b, got %b", want.is_full, got.is_full);
      err_cnt++;
    end
  endtask

  // Monitor: check results, then record the newly accepted transaction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o === 1'b1) begin
        if (pending_rsp_q.size() == 0) begin
          $error("result with no transaction outstanding: %p", rsp_o);
          err_cnt++;
        end else begin
          compare_rsp(rsp_o, pending_rsp_q.pop_front());
        end
      end
      if (start && busy === 1'b0) begin
        rsp_t pred;
        pred = deque_apply(req_i);
        pending_rsp_q.push_back(typed_chk ? typed_rsp : pred);
      end
      if ((start && busy === 1'b0) || valid_o === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WDOG_LIMIT) begin
        $error("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  task automatic add_row(op_e op, logic [31:0] data, bit typed, rsp_t exp);
    stim_row_t row;
    row.op    = op;
    row.data  = data;
    row.typed = typed;
    row.exp   = exp;
    stim_tab.push_back(row);
  endtask

  // Holds start high until the transaction is taken (start high, busy low at an edge).
  task automatic issue_op(op_e op, logic [31:0] data, bit typed, rsp_t exp);
    start         <= 1'b1;
    req_i.mode    <= op;
    req_i.data_in <= data;
    typed_chk     <= typed;
    typed_rsp     <= exp;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  task automatic maybe_idle(int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_rsp_q.size() != 0);
  endtask

  initial begin
    int    idle_pct [4] = '{0, 50, 0, 25};
    int    push_pct;
    int    run_left;
    op_e   op;
    logic [31:0] data;
    rsp_t  none;

    none          = '0;
    rst_ni        = 1'b0;
    start         = 1'b0;
    req_i         = '0;
    typed_chk     = 1'b0;
    typed_rsp     = '0;
    err_cnt       = 0;
    quiet_cycles  = 0;
    dq_head       = 0;
    dq_tail       = 0;
    dq_count      = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pops, extremes at both ends, last element removed
    add_row(OP_POP_FRONT,  32'h0000_0000, 1, rsp_t'{32'sh0, ST_UNDERFLOW, 5'd0, 1'b1, 1'b0});
    add_row(OP_POP_BACK,   32'h1234_5678, 1, rsp_t'{32'sh0, ST_UNDERFLOW, 5'd0, 1'b1, 1'b0});
    add_row(OP_PUSH_BACK,  32'h7FFF_FFFF, 1, rsp_t'{32'sh0, ST_OK, 5'd1, 1'b0, 1'b0});
    add_row(OP_PUSH_FRONT, 32'h8000_0000, 1, rsp_t'{32'sh0, ST_OK, 5'd2, 1'b0, 1'b0});
    add_row(OP_POP_FRONT,  32'h0000_0000, 1,
            rsp_t'{32'sh8000_0000, ST_OK, 5'd1, 1'b0, 1'b0});
    add_row(OP_POP_BACK,   32'h0000_0000, 1,
            rsp_t'{32'sh7FFF_FFFF, ST_OK, 5'd0, 1'b1, 1'b0});
    add_row(OP_PUSH_BACK,  32'hFFFF_FFFF, 1, rsp_t'{32'sh0, ST_OK, 5'd1, 1'b0, 1'b0});
    add_row(OP_PUSH_FRONT, 32'h0000_0000, 1, rsp_t'{32'sh0, ST_OK, 5'd2, 1'b0, 1'b0});
    // fill to DEPTH, both ends, so the pointers wrap
    for (int i = 0; i < 14; i++) begin
      add_row(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
              i[1] ? (32'hAAAA_AAAA ^ i) : (32'h5555_5555 ^ i), 0, none);
    end
    // push when full, either end
    add_row(OP_PUSH_BACK,  32'h0000_0001, 1, rsp_t'{32'sh0, ST_OVERFLOW, 5'd16, 1'b0, 1'b1});
    add_row(OP_PUSH_FRONT, 32'hFFFF_FFFE, 1, rsp_t'{32'sh0, ST_OVERFLOW, 5'd16, 1'b0, 1'b1});
    add_row(OP_POP_BACK,   32'h0000_0000, 0, none);

    foreach (stim_tab[i]) begin
      issue_op(stim_tab[i].op, stim_tab[i].data, stim_tab[i].typed, stim_tab[i].exp);
    end

    // random: push-heavy and pop-heavy runs so the count sweeps between empty and full
    push_pct = 75;
    run_left = $urandom_range(20, 60);
    foreach (idle_pct[ph]) begin
      drain_results();
      for (int n = 0; n < N_RANDOM / 4; n++) begin
        if (run_left == 0) begin
          push_pct = 100 - push_pct;
          run_left = $urandom_range(20, 60);
        end
        run_left--;
        if ($urandom_range(99) < push_pct) begin
          op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        end else begin
          op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
        end
        case ($urandom_range(9))
          0:       data = 32'h8000_0000;
          1:       data = 32'h7FFF_FFFF;
          2:       data = $urandom_range(1) ? 32'h0 : 32'hFFFF_FFFF;
          default: data = $urandom;
        endcase
        maybe_idle(idle_pct[ph]);
        issue_op(op, data, 0, none);
      end
    end

    drain_results();
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (pending_rsp_q.size() != 0) begin
      $error("%0d results never arrived", pending_rsp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cdq_pkg.sv
hdl/cdq_ctrl.sv
hdl/cdq_dpath.sv
hdl/circular_deque.sv
dv/circular_deque_tb.sv
